/* rtl/zsh_pkg.sv */
// Shared types and codes for the zone sensor hold qualifier.
`default_nettype none
package zsh_pkg;

  // Line state codes, observed and held
  localparam logic [1:0] KIND_NORMAL = 2'd0;
  localparam logic [1:0] KIND_ALARM  = 2'd1;
  localparam logic [1:0] KIND_EOL    = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_MASK    = 2'd1;

  typedef struct packed {
    logic [3:0] line_index;
    logic [1:0] line_code;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  held_state;
    logic [15:0] alarm_zones;
    logic [15:0] warning_zones;
    logic [1:0]  panel_status;
  } out_item_t;

endpackage
`default_nettype wire

/* rtl/zone_sensor_hold_qualifier.sv */
// An observation passes through the input register and then the result register to its result transaction.
// Throughput: one observation per cycle unless out_ready stalls the result register; the per-line
// read-modify-write and the panel OR-reduction fit between the input register and the result register.
// Reset (synchronous, rst_n low): all line counts, held states and zone bits clear,
// hold_threshold returns to 3 and unused_mask to 0; no clearing pass is needed.
`default_nettype none
module zone_sensor_hold_qualifier #(
  parameter int unsigned LINES = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire zsh_pkg::in_item_t               in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output zsh_pkg::out_item_t                   out_data,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [zsh_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [zsh_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import zsh_pkg::*;

  logic        out_valid_r;
  out_item_t   out_data_r;
  logic        item_valid;
  in_item_t    item;
  logic        advance;
  out_item_t   result;
  logic [7:0]  hold_threshold_r;
  logic [15:0] unused_mask_r;

  // Move an item into the result register when that register is free or drains
  assign advance   = item_valid && (!out_valid_r || out_ready);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  zsh_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  zsh_line_core #(
    .LINES (LINES)
  ) u_line_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (advance),
    .item           (item),
    .hold_threshold (hold_threshold_r),
    .unused_mask    (unused_mask_r),
    .result         (result)
  );

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_threshold_r <= 8'd3;
      unused_mask_r    <= 16'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_HOLD_THRESHOLD: hold_threshold_r <= cfg_data[7:0];
        CFG_UNUSED_MASK:    unused_mask_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Track result occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Hold result payload
  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= result;
    end
  end

endmodule
`default_nettype wire

/* rtl/zsh_in_stage.sv */
// Input register stage: captures one observation and offers it to the line core.
`default_nettype none
module zsh_in_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire zsh_pkg::in_item_t in_data,
  input  wire logic              advance,
  output logic                   item_valid,
  output zsh_pkg::in_item_t      item
);
  import zsh_pkg::*;

  logic     valid_r;
  in_item_t item_r;

  // Take a new transaction when empty or when the held one moves on this cycle
  assign in_ready   = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // Hold payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
  end

endmodule
`default_nettype wire

/* rtl/zsh_line_core.sv */
// Per-line debounce state, zone bits and result formation for one observation.
`default_nettype none
module zsh_line_core #(
  parameter int unsigned LINES = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire zsh_pkg::in_item_t item,
  input  wire logic [7:0]        hold_threshold,
  input  wire logic [15:0]       unused_mask,
  output zsh_pkg::out_item_t     result
);
  import zsh_pkg::*;

  localparam logic [15:0] LINE_MASK = 16'((33'd1 << LINES) - 33'd1);

  logic [1:0]  last_kind_r [LINES];
  logic [7:0]  hold_count_r [LINES];
  logic [1:0]  line_held_r [LINES];
  logic [15:0] alarm_zone_r;
  logic [15:0] warning_zone_r;

  logic [1:0]  last_kind_nxt [LINES];
  logic [7:0]  hold_count_nxt [LINES];
  logic [1:0]  line_held_nxt [LINES];
  logic [15:0] alarm_zone_nxt;
  logic [15:0] warning_zone_nxt;

  logic [15:0] mask_lines;
  logic        code_active;
  logic [1:0]  held_out;
  logic        any_alarm;
  logic        any_eol;

  assign mask_lines  = unused_mask & LINE_MASK;
  assign code_active = (item.line_code == KIND_ALARM) || (item.line_code == KIND_EOL);

  // Compute next per-line state; only the addressed, in-use line counts
  always_comb begin
    logic       hit;
    logic [8:0] sum;
    alarm_zone_nxt   = alarm_zone_r & ~mask_lines;
    warning_zone_nxt = warning_zone_r & ~mask_lines;
    held_out         = KIND_NORMAL;
    any_alarm        = 1'b0;
    any_eol          = 1'b0;
    for (int i = 0; i < LINES; i++) begin
      hit               = (item.line_index == 4'(i));
      sum               = {1'b0, hold_count_r[i]} + 9'd1;
      last_kind_nxt[i]  = last_kind_r[i];
      hold_count_nxt[i] = hold_count_r[i];
      line_held_nxt[i]  = mask_lines[i] ? KIND_UNUSED : line_held_r[i];
      if (hit && !mask_lines[i]) begin
        if (code_active) begin
          if (last_kind_r[i] != item.line_code) begin
            last_kind_nxt[i]  = item.line_code;
            hold_count_nxt[i] = 8'd1;
          end else if (sum >= {1'b0, hold_threshold}) begin
            hold_count_nxt[i] = hold_threshold;
            line_held_nxt[i]  = item.line_code;
            if (item.line_code == KIND_ALARM) begin
              alarm_zone_nxt[i] = 1'b1;
            end else begin
              warning_zone_nxt[i] = 1'b1;
            end
          end else begin
            hold_count_nxt[i] = sum[7:0];
          end
        end else begin
          last_kind_nxt[i]  = KIND_NORMAL;
          hold_count_nxt[i] = 8'd0;
          line_held_nxt[i]  = KIND_NORMAL;
        end
      end
      // Select the addressed line's held state and reduce panel flags
      if (hit) begin
        held_out = line_held_nxt[i];
      end
      if (line_held_nxt[i] == KIND_ALARM) begin
        any_alarm = 1'b1;
      end
      if (line_held_nxt[i] == KIND_EOL) begin
        any_eol = 1'b1;
      end
    end
  end

  // Form the result from the updated state
  always_comb begin
    result.held_state    = held_out;
    result.alarm_zones   = alarm_zone_nxt;
    result.warning_zones = warning_zone_nxt;
    if (any_alarm) begin
      result.panel_status = KIND_ALARM;
    end else if (any_eol) begin
      result.panel_status = KIND_EOL;
    end else begin
      result.panel_status = KIND_NORMAL;
    end
  end

  // Commit state when an observation is processed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LINES; i++) begin
        last_kind_r[i]  <= KIND_NORMAL;
        hold_count_r[i] <= 8'd0;
        line_held_r[i]  <= KIND_NORMAL;
      end
      alarm_zone_r   <= 16'd0;
      warning_zone_r <= 16'd0;
    end else if (step) begin
      for (int i = 0; i < LINES; i++) begin
        last_kind_r[i]  <= last_kind_nxt[i];
        hold_count_r[i] <= hold_count_nxt[i];
        line_held_r[i]  <= line_held_nxt[i];
      end
      alarm_zone_r   <= alarm_zone_nxt;
      warning_zone_r <= warning_zone_nxt;
    end
  end

endmodule
`default_nettype wire
